// ===== rtl/core/aob_pkg.sv =====
// Shared types and register codes for the alpha overlay blend pipeline.
package aob_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HAS_ALPHA = 3'd4;

    localparam int CFG_DATA_W = 13;
    localparam int COORD_W    = 12;
    localparam int SUM_W      = 16;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] left;
        logic signed [CFG_DATA_W-1:0] top;
        logic        [CFG_DATA_W-1:0] width;
        logic        [CFG_DATA_W-1:0] height;
        logic                         has_alpha;
    } t_win_cfg;

    // After the window decision: pixel to keep (alpha resolved) and blend inputs
    typedef struct packed {
        t_pixel keep;
        t_pixel base;
        t_pixel over;
        logic   blend;
    } t_s1;

    // After the weighted sums
    typedef struct packed {
        t_pixel           keep;
        logic [SUM_W-1:0] sum_blue;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_red;
        logic             blend;
    } t_s2;

endpackage

// ===== rtl/core/aob_window.sv =====
// Stage one: window test and choice of pass, copy or blend for each item.
module aob_window
    import aob_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_win_cfg           i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_pix_x,
    input  logic [COORD_W-1:0] i_pix_y,
    input  t_pixel             i_base,
    input  t_pixel             i_over,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_s1                o_data
);

    logic                 r_valid;
    t_s1                  r_data;
    t_s1                  n_data;
    logic signed [13:0]   x_s;
    logic signed [13:0]   y_s;
    logic signed [14:0]   x_end;
    logic signed [14:0]   y_end;
    logic                 in_win;
    logic                 active;
    logic                 copy;

    // Window bounds without wrap: start <= coord < start + size
    always_comb begin
        x_s   = $signed({2'b00, i_pix_x});
        y_s   = $signed({2'b00, i_pix_y});
        x_end = 15'(i_cfg.left) + $signed({2'b00, i_cfg.width});
        y_end = 15'(i_cfg.top) + $signed({2'b00, i_cfg.height});
        in_win = (x_s >= 14'(i_cfg.left)) && (15'(x_s) < x_end)
              && (y_s >= 14'(i_cfg.top)) && (15'(y_s) < y_end);
        active = in_win && (i_over.alpha != 8'd0);
        copy   = active && i_cfg.has_alpha && (i_base.alpha == 8'd0);
    end

    // Resolve the kept pixel and its alpha
    always_comb begin
        n_data       = '0;
        n_data.base  = i_base;
        n_data.over  = i_over;
        n_data.blend = active && !copy;
        n_data.keep  = copy ? i_over : i_base;
        if (active && !copy && i_cfg.has_alpha) begin
            n_data.keep.alpha = (i_base.alpha > i_over.alpha) ? i_base.alpha : i_over.alpha;
        end
    end

    // Advance when the slot is empty or downstream takes it
    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_data      = r_data;

endmodule

// ===== rtl/core/aob_mult.sv =====
// Stage two: weighted channel sums over*a + base*(255-a).
module aob_mult
    import aob_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_s1  i_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_s2  o_data
);

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;

    function automatic logic [SUM_W-1:0] wsum(input logic [7:0] over, input logic [7:0] base,
                                              input logic [7:0] a);
        logic [7:0] inv;
        inv = 8'd255 - a;
        return SUM_W'(over) * SUM_W'(a) + SUM_W'(base) * SUM_W'(inv);
    endfunction

    // Form the three channel sums
    always_comb begin
        n_data           = '0;
        n_data.keep      = i_data.keep;
        n_data.blend     = i_data.blend;
        n_data.sum_blue  = wsum(i_data.over.blue, i_data.base.blue, i_data.over.alpha);
        n_data.sum_green = wsum(i_data.over.green, i_data.base.green, i_data.over.alpha);
        n_data.sum_red   = wsum(i_data.over.red, i_data.base.red, i_data.over.alpha);
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_data      = r_data;

endmodule

// ===== rtl/core/aob_div.sv =====
// Stage three: divide the sums by 255 and register the output pixel.
module aob_div
    import aob_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_s2    i_data,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_pixel o_pixel
);

    logic   r_valid;
    t_pixel r_pixel;
    t_pixel n_pixel;

    // floor(s/255) for s below 65280: (s + 1 + (s >> 8)) >> 8
    function automatic logic [7:0] div255(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s + SUM_W'(1) + (s >> 8);
        return t[SUM_W-1:8];
    endfunction

    // Pick blended colors or the kept pixel
    always_comb begin
        n_pixel = i_data.keep;
        if (i_data.blend) begin
            n_pixel.blue  = div255(i_data.sum_blue);
            n_pixel.green = div255(i_data.sum_green);
            n_pixel.red   = div255(i_data.sum_red);
        end
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_out_valid = r_valid;
    assign o_pixel     = r_pixel;

endmodule

// ===== rtl/core/alpha_overlay_blend_top.sv =====
// Top level of the alpha overlay blend: configuration registers and three-stage pipeline.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one base pixel with its x/y
//   position and the overlay pixel at that position. Output channel
//   (o_out_valid / i_out_ready) returns the composited pixel, one per item, in order.
//   Configuration is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_wr_data):
//   0 window left, 1 window top (signed), 2 width, 3 height (clamped to MAX_DIM),
//   4 base has alpha. Write it only while the pipeline is empty.
//   Pipeline: three register stages (window test, weighted sums, divide by 255);
//   each item passes through them in that order, and o_out_valid is the valid
//   bit of the last stage.
//   Throughput: one item per clock while i_out_ready is high; the stages each hold one item.
//   Stall: when i_out_ready is low, items pile up in empty stages; o_in_ready
//   drops only once all three stages are full. Nothing is dropped or repeated.
//   Reset: synchronous, active low; empties the pipeline and restores the
//   register defaults (zero window, four-channel base).
module alpha_overlay_blend_top
    import aob_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_W-1:0]    i_pixel_x,
    input  logic [COORD_W-1:0]    i_pixel_y,
    input  logic [7:0]            i_base_blue,
    input  logic [7:0]            i_base_green,
    input  logic [7:0]            i_base_red,
    input  logic [7:0]            i_base_alpha,
    input  logic [7:0]            i_over_blue,
    input  logic [7:0]            i_over_green,
    input  logic [7:0]            i_over_red,
    input  logic [7:0]            i_over_alpha,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_alpha
);

    localparam int DIM_FULL_W = $clog2(MAX_DIM + 1);
    localparam int DIM_W      = (DIM_FULL_W > CFG_DATA_W) ? CFG_DATA_W : DIM_FULL_W;
    localparam int CMP_W      = 18;

    logic signed [CFG_DATA_W-1:0] r_left;
    logic signed [CFG_DATA_W-1:0] r_top;
    logic [DIM_W-1:0]             r_width;
    logic [DIM_W-1:0]             r_height;
    logic                         r_has_alpha;
    logic [DIM_W-1:0]             n_dim;

    t_win_cfg win_cfg;
    t_pixel   base_pix;
    t_pixel   over_pix;
    t_pixel   out_pix;
    t_s1      s1_data;
    t_s2      s2_data;
    logic     s1_valid;
    logic     s1_ready;
    logic     s2_valid;
    logic     s2_ready;

    // Saturate a size write to MAX_DIM
    always_comb begin
        if (CMP_W'(i_cfg_wr_data) > CMP_W'(MAX_DIM)) begin
            n_dim = DIM_W'(MAX_DIM);
        end else begin
            n_dim = DIM_W'(i_cfg_wr_data);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_top       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_has_alpha <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW_LEFT: begin
                    r_left <= $signed(i_cfg_wr_data);
                end
                CFG_WINDOW_TOP: begin
                    r_top <= $signed(i_cfg_wr_data);
                end
                CFG_WINDOW_WIDTH: begin
                    r_width <= n_dim;
                end
                CFG_WINDOW_HEIGHT: begin
                    r_height <= n_dim;
                end
                CFG_BASE_HAS_ALPHA: begin
                    r_has_alpha <= i_cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        win_cfg.left      = r_left;
        win_cfg.top       = r_top;
        win_cfg.width     = CFG_DATA_W'(r_width);
        win_cfg.height    = CFG_DATA_W'(r_height);
        win_cfg.has_alpha = r_has_alpha;
    end

    assign base_pix = '{blue: i_base_blue, green: i_base_green, red: i_base_red,
                        alpha: i_base_alpha};
    assign over_pix = '{blue: i_over_blue, green: i_over_green, red: i_over_red,
                        alpha: i_over_alpha};

    aob_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (win_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pix_x     (i_pixel_x),
        .i_pix_y     (i_pixel_y),
        .i_base      (base_pix),
        .i_over      (over_pix),
        .o_out_valid (s1_valid),
        .i_out_ready (s1_ready),
        .o_data      (s1_data)
    );

    aob_mult u_mult (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s1_valid),
        .o_in_ready  (s1_ready),
        .i_data      (s1_data),
        .o_out_valid (s2_valid),
        .i_out_ready (s2_ready),
        .o_data      (s2_data)
    );

    aob_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s2_valid),
        .o_in_ready  (s2_ready),
        .i_data      (s2_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel     (out_pix)
    );

    assign o_out_blue  = out_pix.blue;
    assign o_out_green = out_pix.green;
    assign o_out_red   = out_pix.red;
    assign o_out_alpha = out_pix.alpha;

    // Oversized width write saturates
    a_width_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (i_cfg_index == CFG_WINDOW_WIDTH)
            && (CMP_W'(i_cfg_wr_data) > CMP_W'(MAX_DIM)))
        |=> (CMP_W'(r_width) == CMP_W'(MAX_DIM)))
        else $error("window width not saturated to MAX_DIM");

    // Input backpressure only when every stage holds an item and output stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (s1_valid && s2_valid && o_out_valid && !i_out_ready))
        else $error("input stalled with a free pipeline slot");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
